[rtl/core/spi_clock_divider_search_unit_defines.svh]
// Assertion macros shared by the SPI clock divider search unit.
`ifndef SPI_CLOCK_DIVIDER_SEARCH_UNIT_DEFINES_SVH
`define SPI_CLOCK_DIVIDER_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scds: implication check failed");

// Next-cycle implication, checked outside reset.
`define SCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scds: next-cycle check failed");

`endif

[rtl/core/scds_pkg.sv]
// Types and constants of the SPI clock divider search unit.
`timescale 1ns / 1ps
package scds_pkg;

  localparam int unsigned RefW        = 28;
  localparam int unsigned ReqW        = 32;
  localparam int unsigned PreW        = 13;
  localparam int unsigned CntW        = 6;
  localparam int unsigned MaxCountN   = 63;
  localparam int unsigned MaxPrescale = 8191;
  localparam logic [RefW-1:0] RefReset = 28'd80000000;

  typedef struct packed {
    logic [ReqW-1:0] requested_hz;
  } req_t;

  typedef struct packed {
    logic            use_sysclk;
    logic [PreW-1:0] prescale;
    logic [CntW-1:0] count_n;
    logic [CntW-1:0] count_high;
    logic [CntW-1:0] count_low;
    logic [31:0]     clock_word;
  } res_t;

endpackage

[rtl/core/scds_chan_if.sv]
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps
interface scds_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/spi_clock_divider_search_unit.sv]
// Top level of the SPI clock divider search unit.
// A request transaction on req_ch carries the wanted SPI clock in hertz; one result
// transaction on res_ch returns the divider settings (bypass bit, prescale, count_n,
// count_high, count_low and the packed clock word). The bus clock frequency is set
// through the APB register at address 0; the user must see that it is written only
// while the unit is idle, as the unit itself does not enforce this. A request at or
// above the bus clock, or below the slowest setting, goes straight to the finish
// state. Otherwise count_n runs from 1 to 63; each step uses one shared restoring
// divider for two estimate divisions and four trial divisions, and an exact match
// ends the search early. One request is in work at a time and req_ch.ready is high
// only when idle. The result sits in an output register, so a new request is taken
// while a result still waits; if the receiver stalls, a finished search holds until
// that register is free. Reset clears the sequencer and the output valid flag and
// loads the bus clock register with 80 MHz.
`timescale 1ns / 1ps
`include "spi_clock_divider_search_unit_defines.svh"
module spi_clock_divider_search_unit
  import scds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  scds_chan_if.sink          req_ch,
  scds_chan_if.source        res_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CycW     = $clog2(RefW);
  localparam int unsigned MinShift = $clog2((MaxPrescale + 1) * (MaxCountN + 1));
  localparam int unsigned ProdW    = MinShift + 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV_A  = 8'b0000_0010,
    S_DIV_B  = 8'b0000_0100,
    S_PREP   = 8'b0000_1000,
    S_MUL    = 8'b0001_0000,
    S_DIV_F  = 8'b0010_0000,
    S_EVAL   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [RefW-1:0] ref_q;
  logic [ReqW-1:0] req_q, req_d;
  logic [CntW-1:0] n_q, n_d;
  logic [1:0]      k_q, k_d;
  logic [RefW-1:0] q2_q, q2_d;
  logic [PreW-1:0] pre_q, pre_d;
  logic [RefW-1:0] f_q, f_d;

  logic            sys_q, sys_d;
  logic [PreW-1:0] best_pre_q, best_pre_d;
  logic [CntW-1:0] best_n_q, best_n_d;
  logic [CntW-1:0] best_lo_q, best_lo_d;
  logic [RefW-1:0] best_f_q, best_f_d;

  // Shared restoring divider: the quotient shifts in where the dividend shifts out.
  logic [RefW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [ReqW-1:0] dvs_q, dvs_d;
  logic [CycW-1:0] cyc_q, cyc_d;
  logic [RefW:0]   rem_sh;
  logic [ReqW-1:0] rem_sub;
  logic            div_ge, div_last;
  logic [RefW-1:0] rem_nx, quo_nx;

  logic            out_valid_q;
  res_t            out_q;
  logic            out_load;

  logic            cfg_wr;
  logic [RefW:0]   guess_sum;
  logic [RefW:0]   guess_m2;
  logic [PreW-1:0] guess_pre;
  logic [CntW:0]   n_inc;
  logic [CntW-1:0] lo_cur;
  logic [ProdW-1:0] prod;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {4'b0, ref_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= RefReset;
    end else if (cfg_wr) begin
      ref_q <= pwdata[RefW-1:0];
    end
  end

  // Divider step
  assign rem_sh   = {rem_q, quo_q[RefW-1]};
  assign div_ge   = {{(ReqW-RefW-1){1'b0}}, rem_sh} >= dvs_q;
  assign rem_sub  = {{(ReqW-RefW-1){1'b0}}, rem_sh} - dvs_q;
  assign rem_nx   = div_ge ? rem_sub[RefW-1:0] : rem_sh[RefW-1:0];
  assign quo_nx   = {quo_q[RefW-2:0], div_ge};
  assign div_last = (cyc_q == CycW'(RefW - 1));

  // Prescale guess: floor estimate minus one, plus k minus one, clamped.
  assign guess_sum = {1'b0, q2_q} + (RefW+1)'(k_q);
  assign guess_m2  = guess_sum - (RefW+1)'(2);
  always_comb begin
    if (guess_sum <= (RefW+1)'(2)) begin
      guess_pre = '0;
    end else if (guess_m2 > (RefW+1)'(MaxPrescale)) begin
      guess_pre = PreW'(MaxPrescale);
    end else begin
      guess_pre = guess_m2[PreW-1:0];
    end
  end

  assign n_inc  = {1'b0, n_q} + (CntW+1)'(1);
  assign lo_cur = n_inc[CntW:1];
  assign prod   = ProdW'({1'b0, pre_q} + (PreW+1)'(1)) * ProdW'(n_inc);

  assign req_ch.ready = (state_q == S_IDLE);
  assign out_load     = (state_q == S_FINISH) && (!out_valid_q || res_ch.ready);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    n_d        = n_q;
    k_d        = k_q;
    q2_d       = q2_q;
    pre_d      = pre_q;
    f_d        = f_q;
    sys_d      = sys_q;
    best_pre_d = best_pre_q;
    best_n_d   = best_n_q;
    best_lo_d  = best_lo_q;
    best_f_d   = best_f_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dvs_d      = dvs_q;
    cyc_d      = cyc_q;

    case (state_q)
      S_IDLE: begin
        if (req_ch.valid) begin
          req_d      = req_ch.payload.requested_hz;
          sys_d      = 1'b0;
          best_pre_d = '0;
          best_n_d   = '0;
          best_lo_d  = '0;
          best_f_d   = '0;
          if (req_ch.payload.requested_hz >= {4'b0, ref_q}) begin
            sys_d   = 1'b1;
            state_d = S_FINISH;
          end else if ((req_ch.payload.requested_hz == '0) ||
                       (req_ch.payload.requested_hz < {4'b0, (ref_q >> MinShift)})) begin
            best_pre_d = PreW'(MaxPrescale);
            best_n_d   = CntW'(MaxCountN);
            state_d    = S_FINISH;
          end else begin
            n_d     = CntW'(1);
            quo_d   = ref_q;
            rem_d   = '0;
            cyc_d   = '0;
            dvs_d   = ReqW'(2);
            state_d = S_DIV_A;
          end
        end
      end
      S_DIV_A: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cyc_d = cyc_q + CycW'(1);
        if (div_last) begin
          // The quotient ref/(n+1) becomes the dividend of the estimate.
          rem_d   = '0;
          cyc_d   = '0;
          dvs_d   = req_q;
          state_d = S_DIV_B;
        end
      end
      S_DIV_B: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cyc_d = cyc_q + CycW'(1);
        if (div_last) begin
          q2_d    = quo_nx;
          k_d     = '0;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        pre_d   = guess_pre;
        state_d = S_MUL;
      end
      S_MUL: begin
        dvs_d   = ReqW'(prod);
        quo_d   = ref_q;
        rem_d   = '0;
        cyc_d   = '0;
        state_d = S_DIV_F;
      end
      S_DIV_F: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cyc_d = cyc_q + CycW'(1);
        if (div_last) begin
          f_d     = quo_nx;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if ({4'b0, f_q} == req_q) begin
          best_pre_d = pre_q;
          best_n_d   = n_q;
          best_lo_d  = lo_cur;
          state_d    = S_FINISH;
        end else begin
          // Below the request, being closer is the same as being faster.
          if (({4'b0, f_q} < req_q) && (f_q > best_f_q)) begin
            best_f_d   = f_q;
            best_pre_d = pre_q;
            best_n_d   = n_q;
            best_lo_d  = lo_cur;
          end
          if (k_q == 2'd3) begin
            if (n_q == CntW'(MaxCountN)) begin
              state_d = S_FINISH;
            end else begin
              n_d     = n_inc[CntW-1:0];
              quo_d   = ref_q;
              rem_d   = '0;
              cyc_d   = '0;
              dvs_d   = ReqW'(n_inc) + ReqW'(1);
              state_d = S_DIV_A;
            end
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_PREP;
          end
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    n_q        <= n_d;
    k_q        <= k_d;
    q2_q       <= q2_d;
    pre_q      <= pre_d;
    f_q        <= f_d;
    sys_q      <= sys_d;
    best_pre_q <= best_pre_d;
    best_n_q   <= best_n_d;
    best_lo_q  <= best_lo_d;
    best_f_q   <= best_f_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dvs_q      <= dvs_d;
    cyc_q      <= cyc_d;
    if (out_load) begin
      out_q.use_sysclk <= sys_q;
      out_q.prescale   <= best_pre_q;
      out_q.count_n    <= best_n_q;
      out_q.count_high <= '0;
      out_q.count_low  <= best_lo_q;
      out_q.clock_word <= {sys_q, best_pre_q, best_n_q, CntW'(0), best_lo_q};
    end
  end

  assign res_ch.valid   = out_valid_q;
  assign res_ch.payload = out_q;

  `SCDS_ASSERT_IMPL(a_bypass_clean, clk_i, rst_ni,
    res_ch.valid && res_ch.payload.use_sysclk,
    (res_ch.payload.prescale == '0) && (res_ch.payload.count_n == '0))
  `SCDS_ASSERT_IMPL(a_low_count, clk_i, rst_ni,
    res_ch.valid && (res_ch.payload.count_low != '0),
    res_ch.payload.count_low == CntW'(({1'b0, res_ch.payload.count_n} + 7'd1) >> 1))
  `SCDS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    req_ch.valid && req_ch.ready, !req_ch.ready)

endmodule
